// ===== rtl/mrlf_pkg.sv =====
package mrlf_pkg;

  localparam int ROUTE_CAPACITY = 32;
  localparam int PORT_COUNT_MAX = 8;
  localparam int FILL_W = $clog2(ROUTE_CAPACITY + 1);
  localparam int ID_W = 8;
  localparam int PORT_W = 3;
  localparam int MASK_W = 8;
  localparam int CNT_W = 4;

  localparam logic [ID_W-1:0] LOCAL_COMPONENT_ID = 8'd1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_LOCAL_SYS = 2'd0;
  localparam logic [1:0] REG_PORT_COUNT = 2'd1;
  localparam logic [1:0] REG_PORT_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    LS_NONE = 2'd0,
    LS_UPDATED = 2'd1,
    LS_ADDED = 2'd2,
    LS_FULL = 2'd3
  } learn_status_t;

  // query token that walks the cell chain
  typedef struct packed {
    logic vld;
    logic fwd;
    logic ign;
    logic bcast;
    logic comp_any;
    logic [ID_W-1:0] sys;
    logic [ID_W-1:0] comp;
    logic [PORT_W-1:0] port;
    logic [FILL_W-1:0] left;
    logic found;
    logic added;
    logic [MASK_W-1:0] hits;
  } tok_t;

endpackage

// ===== rtl/mrlf_cell.sv =====
module mrlf_cell import mrlf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  tok_t tin,
  output tok_t tout
);

  logic [ID_W-1:0] ent_sys;
  logic [ID_W-1:0] ent_comp;
  logic [PORT_W-1:0] ent_port;

  logic used;
  logic hit;
  logic learning;
  logic wr_port;
  logic wr_all;
  tok_t tout_next;

  always_comb begin
    used = (tin.left != '0);
    hit = used && (ent_sys == tin.sys) && (tin.comp_any || ent_comp == tin.comp);
    learning = tin.vld && !tin.fwd && !tin.ign;
    // updated on first match; appended at first free slot
    wr_port = learning && hit && !tin.found;
    wr_all = learning && !used && !tin.found && !tin.added;

    tout_next = tin;
    tout_next.left = used ? tin.left - FILL_W'(1) : '0;
    if (wr_port) begin
      tout_next.found = 1'b1;
    end
    if (wr_all) begin
      tout_next.added = 1'b1;
    end
    if (tin.vld && tin.fwd && !tin.bcast && hit) begin
      tout_next.hits = tin.hits | (MASK_W'(1) << ent_port);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.vld <= 1'b0;
    end else begin
      tout.vld <= tout_next.vld;
    end
    tout.fwd <= tout_next.fwd;
    tout.ign <= tout_next.ign;
    tout.bcast <= tout_next.bcast;
    tout.comp_any <= tout_next.comp_any;
    tout.sys <= tout_next.sys;
    tout.comp <= tout_next.comp;
    tout.port <= tout_next.port;
    tout.left <= tout_next.left;
    tout.found <= tout_next.found;
    tout.added <= tout_next.added;
    tout.hits <= tout_next.hits;
  end

  always_ff @(posedge clk) begin
    if (wr_all) begin
      ent_sys <= tin.sys;
      ent_comp <= tin.comp;
    end
    if (wr_all || wr_port) begin
      ent_port <= tin.port;
    end
  end

endmodule

// ===== rtl/message_route_learn_forward_top.sv =====
// Learning route table: one transaction at a time; busy holds off start until the
// result strobe (done), and start may be taken again in the cycle done is high.
// The query token walks one cell per cycle through the 32-cell route chain,
// which lies between an entry register and a result register.
// Reset (rst, synchronous) empties the table and restores local id 1, 8 ports,
// enable mask 0. The receiver cannot stall: done lasts exactly one cycle.
module message_route_learn_forward_top import mrlf_pkg::*; (
  input  logic clk,
  input  logic rst,
  // APB-style register port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  // command
  input  logic start,
  output logic busy,
  input  logic action,
  input  logic [ID_W-1:0] source_system,
  input  logic [ID_W-1:0] source_component,
  input  logic [PORT_W-1:0] ingress_port,
  input  logic signed [8:0] target_system,
  input  logic signed [8:0] target_component,
  // result
  output logic done,
  output logic [MASK_W-1:0] forward_mask,
  output logic [1:0] learn_status
);

  // ---------------- configuration registers ----------------
  logic [ID_W-1:0] local_system_id;
  logic [CNT_W-1:0] active_port_count;
  logic [MASK_W-1:0] port_enable_mask;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_system_id <= 8'd1;
      active_port_count <= 4'd8;
      port_enable_mask <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LOCAL_SYS: local_system_id <= pwdata[ID_W-1:0];
        REG_PORT_COUNT: active_port_count <= pwdata[CNT_W-1:0];
        REG_PORT_ENABLE: port_enable_mask <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOCAL_SYS: prdata = 32'(local_system_id);
      REG_PORT_COUNT: prdata = 32'(active_port_count);
      REG_PORT_ENABLE: prdata = 32'(port_enable_mask);
      default: prdata = '0;
    endcase
  end

  // ---------------- token injection ----------------
  // Learn and forward share one token: sys/comp carry the source for a learn
  // and the target for a forward; port carries the ingress port either way.
  logic [FILL_W-1:0] fill_count;
  logic accept;
  tok_t chain [ROUTE_CAPACITY+1];
  tok_t inj_next;

  assign accept = start && !busy;

  always_comb begin
    inj_next = '0;
    inj_next.vld = accept;
    inj_next.fwd = action;
    inj_next.port = ingress_port;
    inj_next.left = fill_count;
    if (action) begin
      // target 0 or negative: flood; component 0 or negative: wildcard
      inj_next.bcast = target_system[8] || (target_system == '0);
      inj_next.comp_any = target_component[8] || (target_component == '0);
      inj_next.sys = target_system[ID_W-1:0];
      inj_next.comp = target_component[ID_W-1:0];
    end else begin
      // own echoes and system 0 are never learned
      inj_next.ign = (source_system == '0) ||
                     ((source_system == local_system_id) &&
                      (source_component == LOCAL_COMPONENT_ID));
      inj_next.sys = source_system;
      inj_next.comp = source_component;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= inj_next.vld;
    end
    chain[0].fwd <= inj_next.fwd;
    chain[0].ign <= inj_next.ign;
    chain[0].bcast <= inj_next.bcast;
    chain[0].comp_any <= inj_next.comp_any;
    chain[0].sys <= inj_next.sys;
    chain[0].comp <= inj_next.comp;
    chain[0].port <= inj_next.port;
    chain[0].left <= inj_next.left;
    chain[0].found <= inj_next.found;
    chain[0].added <= inj_next.added;
    chain[0].hits <= inj_next.hits;
  end

  // ---------------- cell chain ----------------
  // Each cell holds one route entry. Entries are filled in order, so the
  // token's "left" count tells a cell whether it is in use; the first cell
  // that sees left == 0 is where a new route is appended.
  for (genvar i = 0; i < ROUTE_CAPACITY; i++) begin : g_cell
    mrlf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .tin  (chain[i]),
      .tout (chain[i+1])
    );
  end

  // ---------------- result ----------------
  tok_t fin;
  logic [CNT_W-1:0] n_eff;
  logic [MASK_W-1:0] allowed;
  logic [MASK_W-1:0] mask_next;
  learn_status_t status_next;

  assign fin = chain[ROUTE_CAPACITY];

  always_comb begin
    // port count is clamped; ports past it, the ingress port and disabled
    // ports are never sent to
    n_eff = (active_port_count > CNT_W'(PORT_COUNT_MAX)) ?
            CNT_W'(PORT_COUNT_MAX) : active_port_count;
    for (int p = 0; p < MASK_W; p++) begin
      allowed[p] = (CNT_W'(p) < n_eff) && port_enable_mask[p] &&
                   (fin.port != PORT_W'(p));
    end
    mask_next = '0;
    status_next = LS_NONE;
    if (fin.fwd) begin
      mask_next = fin.bcast ? allowed : (fin.hits & allowed);
    end else if (!fin.ign) begin
      if (fin.found) begin
        status_next = LS_UPDATED;
      end else if (fin.added) begin
        status_next = LS_ADDED;
      end else begin
        status_next = LS_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      fill_count <= '0;
    end else begin
      done <= fin.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (fin.vld) begin
        busy <= 1'b0;
      end
      if (fin.vld && !fin.fwd && fin.added) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
    forward_mask <= mask_next;
    learn_status <= status_next;
  end

endmodule
